// File: rtl/frp_pkg.sv
// ----------------------------------------------------------------------------
// FASTA record parser package
// Field widths, byte class codes, character codes and the payload types
// shared by the channel interfaces, the step logic and the core.
// ----------------------------------------------------------------------------
package frp_pkg;

	// payload field widths, fixed by the channel format
	localparam int BYTE_W  = 8;
	localparam int CLASS_W = 2;
	localparam int RECN_W  = 24;
	localparam int POS_W   = 32;
	localparam int HLEN_W  = 16;

	// byte classes
	localparam logic [CLASS_W-1:0] CLS_IGNORED = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_HEADER  = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_SEQ     = 2'd2;

	// characters of interest
	localparam logic [BYTE_W-1:0] CHAR_NL     = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_MARKER = 8'h3E;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              final_byte;
	} text_item_t;

	typedef struct packed {
		logic [CLASS_W-1:0] byte_class;
		logic [RECN_W-1:0]  record_number;
		logic [POS_W-1:0]   base_position;
		logic               record_closed;
		logic [POS_W-1:0]   closed_seq_length;
		logic [HLEN_W-1:0]  closed_header_length;
		logic [POS_W-1:0]   total_bases;
		logic [POS_W-1:0]   longest_record;
		logic [POS_W-1:0]   shortest_record;
		logic [RECN_W-1:0]  records_seen;
	} result_item_t;

	// line and record tracking flags
	typedef struct packed {
		logic in_header_line;
		logic at_line_start;
		logic record_open;
	} line_flags_t;

endpackage

// File: rtl/frp_text_if.sv
// ----------------------------------------------------------------------------
// FASTA text channel
// Valid/ready channel carrying one text byte and its final-byte mark.
// ----------------------------------------------------------------------------
interface frp_text_if;
	logic               valid;
	logic               ready;
	frp_pkg::text_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/frp_result_if.sv
// ----------------------------------------------------------------------------
// FASTA result channel
// Valid/ready channel carrying one classification result per text byte.
// ----------------------------------------------------------------------------
interface frp_result_if;
	logic                 valid;
	logic                 ready;
	frp_pkg::result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/fasta_record_parser_core.sv
// ----------------------------------------------------------------------------
// FASTA record parser core
// Classifies a FASTA text stream byte by byte and reports record closes and
// running sequence statistics.
// ----------------------------------------------------------------------------
// Pipeline: a byte taken is held in the input register, then its result
// is held in the result register facing the consumer.
// Throughput: one byte per cycle while the consumer does not stall.
// Reset: arst_n clears both pipeline valids and returns the parser to the
// start of a file with no record open, zero totals and shortest all ones.
// ----------------------------------------------------------------------------
module fasta_record_parser_core #(
	parameter int LEN_BITS = 32,
	parameter int HDR_BITS = 16,
	parameter int REC_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	frp_text_if.sink            text,
	frp_result_if.source        result
);
	import frp_pkg::*;

	// Stage 1: the accepted request waits here until the result register
	// has room.
	logic       valid_s1;
	text_item_t item_s1;

	// Stage 2: the result register facing the consumer.
	logic         valid_s2;
	result_item_t res_s2;

	// Parser state, updated only as a byte moves from stage 1 to stage 2.
	line_flags_t         flags_q;
	logic [REC_BITS-1:0] rec_cnt_q;
	logic [LEN_BITS-1:0] seq_len_q;
	logic [HDR_BITS-1:0] hdr_len_q;
	logic [LEN_BITS-1:0] total_q;
	logic [LEN_BITS-1:0] max_len_q;
	logic [LEN_BITS-1:0] min_len_q;

	line_flags_t         flags_nxt;
	logic [REC_BITS-1:0] rec_cnt_nxt;
	logic [LEN_BITS-1:0] seq_len_nxt;
	logic [HDR_BITS-1:0] hdr_len_nxt;
	logic [LEN_BITS-1:0] total_nxt;
	logic [LEN_BITS-1:0] max_len_nxt;
	logic [LEN_BITS-1:0] min_len_nxt;
	result_item_t        res_nxt;

	logic take_in;
	logic advance;

	// Advance stage 1 whenever the result register is empty or being drained;
	// accept a new request whenever stage 1 is empty or advancing.
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign text.ready = !valid_s1 || advance;
	assign take_in    = text.valid && text.ready;

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	frp_step #(
		.LEN_BITS (LEN_BITS),
		.HDR_BITS (HDR_BITS),
		.REC_BITS (REC_BITS)
	) u_step (
		.item        (item_s1),
		.flags       (flags_q),
		.rec_cnt     (rec_cnt_q),
		.seq_len     (seq_len_q),
		.hdr_len     (hdr_len_q),
		.total       (total_q),
		.max_len     (max_len_q),
		.min_len     (min_len_q),
		.flags_nxt   (flags_nxt),
		.rec_cnt_nxt (rec_cnt_nxt),
		.seq_len_nxt (seq_len_nxt),
		.hdr_len_nxt (hdr_len_nxt),
		.total_nxt   (total_nxt),
		.max_len_nxt (max_len_nxt),
		.min_len_nxt (min_len_nxt),
		.res         (res_nxt)
	);

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers: load on transfer, hold otherwise.
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= text.data;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	// Parser state: commit the step result as the byte leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q.in_header_line <= 1'b0;
			flags_q.at_line_start  <= 1'b1;
			flags_q.record_open    <= 1'b0;
			rec_cnt_q              <= '0;
			seq_len_q              <= '0;
			hdr_len_q              <= '0;
			total_q                <= '0;
			max_len_q              <= '0;
			min_len_q              <= '1;
		end else if (advance) begin
			flags_q   <= flags_nxt;
			rec_cnt_q <= rec_cnt_nxt;
			seq_len_q <= seq_len_nxt;
			hdr_len_q <= hdr_len_nxt;
			total_q   <= total_nxt;
			max_len_q <= max_len_nxt;
			min_len_q <= min_len_nxt;
		end
	end

endmodule

// File: rtl/frp_step.sv
// ----------------------------------------------------------------------------
// FASTA parser step
// Classifies one byte against the current parser state and returns the
// next state together with the result for that byte.
// ----------------------------------------------------------------------------
module frp_step #(
	parameter int LEN_BITS = 32,
	parameter int HDR_BITS = 16,
	parameter int REC_BITS = 24
) (
	input  frp_pkg::text_item_t   item,
	input  frp_pkg::line_flags_t  flags,
	input  logic [REC_BITS-1:0]   rec_cnt,
	input  logic [LEN_BITS-1:0]   seq_len,
	input  logic [HDR_BITS-1:0]   hdr_len,
	input  logic [LEN_BITS-1:0]   total,
	input  logic [LEN_BITS-1:0]   max_len,
	input  logic [LEN_BITS-1:0]   min_len,
	output frp_pkg::line_flags_t  flags_nxt,
	output logic [REC_BITS-1:0]   rec_cnt_nxt,
	output logic [LEN_BITS-1:0]   seq_len_nxt,
	output logic [HDR_BITS-1:0]   hdr_len_nxt,
	output logic [LEN_BITS-1:0]   total_nxt,
	output logic [LEN_BITS-1:0]   max_len_nxt,
	output logic [LEN_BITS-1:0]   min_len_nxt,
	output frp_pkg::result_item_t res
);
	import frp_pkg::*;

	logic                is_nl;
	logic                is_open;
	logic                close_marker;
	logic                close_final;
	logic                do_fold;
	logic [LEN_BITS-1:0] fold_len;
	logic [LEN_BITS-1:0] mid_seq;
	logic [HDR_BITS-1:0] mid_hdr;
	logic [CLASS_W-1:0]  cls;
	logic [LEN_BITS-1:0] pos;
	line_flags_t         mid;

	assign is_nl   = (item.text_byte == CHAR_NL);
	assign is_open = !is_nl && flags.at_line_start && (item.text_byte == CHAR_MARKER);

	always_comb begin
		mid          = flags;
		rec_cnt_nxt  = rec_cnt;
		mid_seq      = seq_len;
		mid_hdr      = hdr_len;
		cls          = CLS_IGNORED;
		pos          = '0;
		close_marker = 1'b0;
		if (is_nl) begin
			mid.in_header_line = 1'b0;
			mid.at_line_start  = 1'b1;
		end else if (is_open) begin
			close_marker = flags.record_open;
			if (rec_cnt != '1) begin
				rec_cnt_nxt = rec_cnt + 1'b1;
			end
			mid.record_open    = 1'b1;
			mid.in_header_line = 1'b1;
			mid.at_line_start  = 1'b0;
			mid_seq            = '0;
			mid_hdr            = '0;
		end else begin
			mid.at_line_start = 1'b0;
			if (flags.record_open) begin
				if (flags.in_header_line) begin
					cls = CLS_HEADER;
					if (hdr_len != '1) begin
						mid_hdr = hdr_len + 1'b1;
					end
				end else begin
					cls = CLS_SEQ;
					pos = seq_len;
					if (seq_len != '1) begin
						mid_seq = seq_len + 1'b1;
					end
				end
			end
		end
	end

	// Final byte closes whatever is still open and rewinds the line state.
	assign close_final = item.final_byte && mid.record_open;

	always_comb begin
		flags_nxt = mid;
		if (item.final_byte) begin
			flags_nxt.record_open    = 1'b0;
			flags_nxt.in_header_line = 1'b0;
			flags_nxt.at_line_start  = 1'b1;
		end
	end

	assign seq_len_nxt = mid_seq;
	assign hdr_len_nxt = mid_hdr;

	// At most one non-empty length is folded per byte; a marker that is also
	// the final byte folds a further empty record, which only pulls min to 0.
	assign do_fold  = close_marker || close_final;
	assign fold_len = close_marker ? seq_len : mid_seq;

	always_comb begin
		total_nxt   = total;
		max_len_nxt = max_len;
		min_len_nxt = min_len;
		if (do_fold) begin
			total_nxt = total + fold_len;
			if (fold_len > max_len) begin
				max_len_nxt = fold_len;
			end
			if (fold_len < min_len) begin
				min_len_nxt = fold_len;
			end
			if (close_marker && close_final) begin
				min_len_nxt = '0;
			end
		end
	end

	always_comb begin
		res.byte_class           = cls;
		res.record_number        = (rec_cnt_nxt != '0) ?
			RECN_W'(rec_cnt_nxt - 1'b1) : '0;
		res.base_position        = POS_W'(pos);
		res.record_closed        = do_fold;
		res.closed_seq_length    = do_fold ? POS_W'(fold_len) : '0;
		res.closed_header_length = close_marker ? HLEN_W'(hdr_len) :
			(close_final ? HLEN_W'(mid_hdr) : '0);
		res.total_bases          = POS_W'(total_nxt);
		res.longest_record       = POS_W'(max_len_nxt);
		res.shortest_record      = POS_W'(min_len_nxt);
		res.records_seen         = RECN_W'(rec_cnt_nxt);
	end

endmodule

// File: test/tb_fasta_record_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FASTA record parser core testbench
// Feeds the parser directed and randomly built FASTA text under random sender
// gaps and receiver stalls. An in-bench tracker predicts every result word
// from the accepted requests and checks the result channel word by word.
// ----------------------------------------------------------------------------
module tb_fasta_record_parser_core;

	import frp_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_BYTES = 1700;
	// well beyond any header the random records build
	localparam int LONG_HEADER  = 200;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_MOSTLY,
		RDY_PERIODIC
	} ready_mode_e;

	// ------------------------------------------------------------------------
	// Parser state tracker: predicts each result and holds the queue of
	// results still owed by the core.
	// ------------------------------------------------------------------------
	class fasta_parse_tracker;
		logic              in_header  = 1'b0;
		logic              line_start = 1'b1;
		logic              rec_open   = 1'b0;
		logic [RECN_W-1:0] rec_count  = '0;
		logic [POS_W-1:0]  seq_len    = '0;
		logic [HLEN_W-1:0] hdr_len    = '0;
		logic [POS_W-1:0]  base_sum   = '0;
		logic [POS_W-1:0]  max_len    = '0;
		logic [POS_W-1:0]  min_len    = '1;

		result_item_t pending_results[$];
		int           fault_count   = 0;
		int           checked_count = 0;
		int           close_count   = 0;
		bit           hdr_saturated = 0;

		function int pending();
			return pending_results.size();
		endfunction

		function void fold_length(logic [POS_W-1:0] len);
			base_sum = base_sum + len;
			if (len > max_len)
				max_len = len;
			if (len < min_len)
				min_len = len;
		endfunction

		// Advance the parser by one accepted request and queue its result.
		function void take_byte(text_item_t req);
			result_item_t res;
			res = '0;
			if (req.text_byte == CHAR_NL) begin
				in_header  = 1'b0;
				line_start = 1'b1;
			end else if (line_start && req.text_byte == CHAR_MARKER) begin
				if (rec_open) begin
					res.record_closed        = 1'b1;
					res.closed_seq_length    = seq_len;
					res.closed_header_length = hdr_len;
					fold_length(seq_len);
				end
				if (rec_count != '1)
					rec_count++;
				rec_open   = 1'b1;
				seq_len    = '0;
				hdr_len    = '0;
				in_header  = 1'b1;
				line_start = 1'b0;
			end else begin
				line_start = 1'b0;
				if (rec_open) begin
					if (in_header) begin
						res.byte_class = CLS_HEADER;
						if (hdr_len != '1)
							hdr_len++;
						else
							hdr_saturated = 1;
					end else begin
						res.byte_class    = CLS_SEQ;
						res.base_position = seq_len;
						if (seq_len != '1)
							seq_len++;
					end
				end
			end

			if (req.final_byte) begin
				if (rec_open) begin
					if (!res.record_closed) begin
						res.record_closed        = 1'b1;
						res.closed_seq_length    = seq_len;
						res.closed_header_length = hdr_len;
					end
					fold_length(seq_len);
					rec_open = 1'b0;
				end
				in_header  = 1'b0;
				line_start = 1'b1;
			end

			res.record_number   = (rec_count != '0) ? rec_count - 1'b1 : '0;
			res.total_bases     = base_sum;
			res.longest_record  = max_len;
			res.shortest_record = min_len;
			res.records_seen    = rec_count;
			pending_results.push_back(res);
		endfunction

		function void compare_field(string field, logic [POS_W-1:0] want,
				logic [POS_W-1:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, got %0d", field, want, got);
				fault_count++;
			end
		endfunction

		// Check one accepted result against the oldest prediction.
		function void match_result(result_item_t got);
			result_item_t want;
			if (pending_results.size() == 0) begin
				$error("result word arrived with no request outstanding");
				fault_count++;
				return;
			end
			want = pending_results.pop_front();
			checked_count++;
			if (want.record_closed)
				close_count++;
			compare_field("byte_class", want.byte_class, got.byte_class);
			compare_field("record_number", want.record_number, got.record_number);
			compare_field("base_position", want.base_position, got.base_position);
			compare_field("record_closed", want.record_closed, got.record_closed);
			compare_field("closed_seq_length", want.closed_seq_length,
				got.closed_seq_length);
			compare_field("closed_header_length", want.closed_header_length,
				got.closed_header_length);
			compare_field("total_bases", want.total_bases, got.total_bases);
			compare_field("longest_record", want.longest_record, got.longest_record);
			compare_field("shortest_record", want.shortest_record, got.shortest_record);
			compare_field("records_seen", want.records_seen, got.records_seen);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	frp_text_if   text_ch();
	frp_result_if result_ch();

	fasta_parse_tracker tracker = new;

	int          sent_count  = 0;
	int          burst_left  = 0;
	int          cycle_count = 0;
	int          mode_left   = 0;
	ready_mode_e ready_mode  = RDY_ALWAYS;

	fasta_record_parser_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Watchdog: give up if the run stalls well past its slowest correct pace.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("fasta_record_parser_core test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Channel monitor. Values read here are those from before this edge's
	// updates, i.e. exactly what the core sampled.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (text_ch.valid && text_ch.ready)
				tracker.take_byte(text_ch.data);
			if (result_ch.valid && result_ch.ready)
				tracker.match_result(result_ch.data);
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver: switch between stall patterns at random intervals
	// so back-pressure lands on every phase of the pipeline, with spells of
	// no stalling in between.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode = ready_mode_e'($urandom_range(0, 3));
			mode_left  = $urandom_range(32, 256);
		end else begin
			mode_left--;
		end
		case (ready_mode)
			RDY_ALWAYS: begin
				result_ch.ready <= 1'b1;
			end
			RDY_COIN: begin
				result_ch.ready <= 1'($urandom_range(0, 1));
			end
			RDY_MOSTLY: begin
				result_ch.ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				// hold ready low while mode_left modulo sixteen is below five
				result_ch.ready <= ((mode_left % 16) >= 5);
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Sender. Each call presents one request and returns at the edge that
	// accepts it. Bursts of random length are separated by random gaps.
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24)
				: $urandom_range(0, 3);
			if (gap != 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		text_ch.valid <= 1'b1;
		text_ch.data  <= '{text_byte: b, final_byte: fin};
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		sent_count++;
	endtask

	// Send a string; the last character optionally carries the final mark.
	task automatic send_text(input string s, input logic fin_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], fin_last && (i == s.len() - 1));
	endtask

	// Drop valid and hold off until every outstanding result has come back.
	task automatic drain();
		text_ch.valid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
	endtask

	function automatic logic [BYTE_W-1:0] any_but_newline();
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom_range(0, 255));
		return (b == CHAR_NL) ? CHAR_MARKER : b;
	endfunction

	// Mostly nucleotide letters, now and then any byte but a newline.
	function automatic logic [BYTE_W-1:0] base_letter();
		string letters;
		letters = "ACGTNacgtn";
		if ($urandom_range(0, 19) == 0)
			return any_but_newline();
		return letters[$urandom_range(0, letters.len() - 1)];
	endfunction

	function automatic logic [BYTE_W-1:0] noise_byte();
		case ($urandom_range(0, 3))
			0:       return CHAR_NL;
			1:       return CHAR_MARKER;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// One random record: mostly well formed with random content, the rest
	// noise and broken fragments, now and then ending the file.
	task automatic send_record();
		int lines;
		if ($urandom_range(0, 99) < 80) begin
			send_byte(CHAR_MARKER, 1'b0);
			repeat ($urandom_range(0, 12))
				send_byte(any_but_newline(), 1'b0);
			send_byte(CHAR_NL, 1'b0);
			lines = $urandom_range(0, 4);
			for (int l = 0; l < lines; l++) begin
				repeat ($urandom_range(0, 24))
					send_byte(base_letter(), 1'b0);
				// drop the odd line ending so the next marker lands mid-line
				if ($urandom_range(0, 15) != 0)
					send_byte(CHAR_NL, 1'b0);
			end
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 2))
					0:       send_byte(CHAR_NL, 1'b1);
					1:       send_byte(CHAR_MARKER, 1'b1);
					default: send_byte(base_letter(), 1'b1);
				endcase
			end
		end else begin
			repeat ($urandom_range(1, 10))
				send_byte(noise_byte(), ($urandom_range(0, 29) == 0));
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int  random_start;
		bit  mid_pause_done;

		arst_n          = 1'b0;
		text_ch.valid   = 1'b0;
		text_ch.data    = '0;
		mid_pause_done  = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. Junk before the first header: dropped, all bits
		// high then low, and it still ends line start.
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(CHAR_NL, 1'b0);
		// header with a marker inside it, then sequence with a marker inside
		// it and an empty line
		send_text(">h>1\nAC>\n\n", 1'b0);
		// a marker closes the previous record; a record with an empty header
		// then closes on the final byte
		send_text(">\nG", 1'b1);
		// final byte with no record open
		send_byte("T", 1'b1);
		// marker as the final byte with nothing open: opens and closes empty
		send_byte(CHAR_MARKER, 1'b1);
		// marker as the final byte after a record: both enter the totals
		send_text(">x\nA\n>", 1'b1);
		// newline as the final byte
		send_byte(CHAR_NL, 1'b1);

		// Hold off until the pipeline is empty before the long header.
		drain();

		// One long header, then a short sequence closed by the final byte.
		send_byte(CHAR_MARKER, 1'b0);
		repeat (LONG_HEADER)
			send_byte(any_but_newline(), 1'b0);
		send_text("\nACGT", 1'b1);
		drain();

		// Random records, with one full pause half way through.
		random_start = sent_count;
		while (sent_count - random_start < RANDOM_BYTES) begin
			send_record();
			if (!mid_pause_done && sent_count - random_start >= RANDOM_BYTES / 2) begin
				drain();
				mid_pause_done = 1;
			end
		end

		// Wait for the last results, then give the pipeline time to show
		// any stray extra word.
		drain();
		repeat (8) @(posedge clk);

		$display("Run covered %0d text bytes and %0d result words, %0d record closes.",
			sent_count, tracker.checked_count, tracker.close_count);
		$display("Records opened: %0d; header length saturation %s.",
			tracker.rec_count, tracker.hdr_saturated ? "reached" : "not reached");

		if (tracker.fault_count == 0 && tracker.pending() == 0) begin
			$display("fasta_record_parser_core test passed");
		end else begin
			$display("fasta_record_parser_core test failed");
		end
		$finish;
	end

endmodule

// File: fasta_record_parser_core.f
rtl/frp_pkg.sv
rtl/frp_text_if.sv
rtl/frp_result_if.sv
rtl/frp_step.sv
rtl/fasta_record_parser_core.sv
test/tb_fasta_record_parser_core.sv
